// ----- rtl/core/pcce_pkg.sv -----
// Package: shared constants, codes and the result record of the counter/clock/encoder panel.
package pcce_pkg;

    typedef enum logic [1:0] {
        OP_PULSE     = 2'd0,
        OP_BEEP_DONE = 2'd1,
        OP_TICK      = 2'd2,
        OP_ENCODER   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SOUND_ENABLE      = 2'd0,
        CFG_LED_ENABLE        = 2'd1,
        CFG_BATTERY_MODE      = 2'd2,
        CFG_BACKLIGHT_TIMEOUT = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 8;

    localparam logic [15:0] BG_LIMIT             = 16'd20;
    localparam logic [15:0] MINUTE_PULSES_MAX    = 16'hFFFF;
    localparam logic [2:0]  FIFTHS_PER_SECOND    = 3'd5;
    localparam logic [2:0]  DEBOUNCE_SAMPLES     = 3'd5;
    localparam logic [5:0]  SECONDS_PER_MINUTE   = 6'd60;
    localparam logic [5:0]  MINUTES_PER_HOUR     = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY        = 5'd24;
    localparam logic [6:0]  KNOB_MAX             = 7'd120;
    localparam logic [7:0]  BACKLIGHT_TIMEOUT_RST = 8'd10;

    typedef struct packed {
        logic [2:0]  indicators;
        logic [3:0]  time_pulses;
        logic [31:0] pulse_total;
        logic [4:0]  background_last_minute;
        logic [31:0] background_sum;
        logic [31:0] valid_minutes;
        logic [31:0] elapsed_seconds;
        logic [15:0] day_count;
        logic [6:0]  knob_position;
        logic [6:0]  knob_position_double;
        logic [15:0] press_count;
    } result_t;

endpackage

// ----- rtl/core/pulse_counter_clock_encoder_panel.sv -----
// Top level: pulse counter, real-time clock, backlight timer and encoder/button decoder.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+------------------------------------------
//  item      | item_valid / item_ready        | operation, phase_a, phase_b, button
//  result    | result_valid / result_ready    | indicators .. press_count (11 fields)
//  config    | cfg_write (no wait)            | cfg_index, cfg_data
//
// One transaction per cycle while item_ready is high: the state update is one
// pass of counter logic that ends in the result register, or in the skid
// register while an earlier result waits unread. A two-entry output queue
// (result register plus skid register) keeps item_ready high while one
// finished result waits; item_ready drops only when both entries are full.
// Reset clears all state, backlight on, timeout 10 s, and needs no clearing pass.
module pulse_counter_clock_encoder_panel (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        operation,
    input  logic                              phase_a,
    input  logic                              phase_b,
    input  logic                              button,

    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [2:0]                        indicators,
    output logic [3:0]                        time_pulses,
    output logic [31:0]                       pulse_total,
    output logic [4:0]                        background_last_minute,
    output logic [31:0]                       background_sum,
    output logic [31:0]                       valid_minutes,
    output logic [31:0]                       elapsed_seconds,
    output logic [15:0]                       day_count,
    output logic [6:0]                        knob_position,
    output logic [6:0]                        knob_position_double,
    output logic [15:0]                       press_count,

    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [pcce_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcce_pkg::*;

    // configuration
    logic        sound_enable_reg;
    logic        led_enable_reg;
    logic        battery_mode_reg;
    logic [7:0]  backlight_timeout_reg;

    // state
    logic [31:0] pulse_counter_reg,    pulse_counter_next;
    logic [15:0] minute_pulses_reg,    minute_pulses_next;
    logic [4:0]  last_bg_reg,          last_bg_next;
    logic [31:0] bg_total_reg,         bg_total_next;
    logic [31:0] good_minutes_reg,     good_minutes_next;
    logic [2:0]  fifth_count_reg,      fifth_count_next;
    logic [5:0]  seconds_reg,          seconds_next;
    logic [5:0]  minutes_reg,          minutes_next;
    logic [4:0]  hours_reg,            hours_next;
    logic [15:0] days_reg,             days_next;
    logic [31:0] seconds_total_reg,    seconds_total_next;
    logic        backlight_reg,        backlight_next;
    logic [7:0]  backlight_secs_reg,   backlight_secs_next;
    logic        beeper_reg,           beeper_next;
    logic        led_reg,              led_next;
    logic [1:0]  last_phase_reg,       last_phase_next;
    logic [1:0]  quarter_steps_reg,    quarter_steps_next;
    logic [6:0]  knob_single_reg,      knob_single_next;
    logic [6:0]  knob_double_reg,      knob_double_next;
    logic        button_held_reg,      button_held_next;
    logic [2:0]  debounce_reg,         debounce_next;
    logic [15:0] presses_reg,          presses_next;
    logic [3:0]  time_pulses_next;

    // output queue
    logic        head_valid_reg;
    logic        skid_valid_reg;
    result_t     head_reg;
    result_t     skid_reg;
    result_t     result_next;

    logic        push;
    logic        pop;
    op_t         op;

    // temporaries
    logic        bl_state_t0;
    logic [7:0]  bl_secs_t0;
    logic [2:0]  fifth_inc;
    logic        sec_tick;
    logic [5:0]  sec_t1;
    logic [5:0]  min_t1;
    logic [4:0]  hour_t1;
    logic [1:0]  phase_now;
    logic [1:0]  phase_diff;
    logic [1:0]  qs_t1;
    logic        wake;
    logic [2:0]  deb_inc;

    assign item_ready = !skid_valid_reg;
    assign push       = item_valid && item_ready;
    assign pop        = head_valid_reg && result_ready;
    assign op         = op_t'(operation);

    always_comb
    begin
        pulse_counter_next  = pulse_counter_reg;
        minute_pulses_next  = minute_pulses_reg;
        last_bg_next        = last_bg_reg;
        bg_total_next       = bg_total_reg;
        good_minutes_next   = good_minutes_reg;
        fifth_count_next    = fifth_count_reg;
        seconds_next        = seconds_reg;
        minutes_next        = minutes_reg;
        hours_next          = hours_reg;
        days_next           = days_reg;
        seconds_total_next  = seconds_total_reg;
        backlight_next      = backlight_reg;
        backlight_secs_next = backlight_secs_reg;
        beeper_next         = beeper_reg;
        led_next            = led_reg;
        last_phase_next     = last_phase_reg;
        quarter_steps_next  = quarter_steps_reg;
        knob_single_next    = knob_single_reg;
        knob_double_next    = knob_double_reg;
        button_held_next    = button_held_reg;
        debounce_next       = debounce_reg;
        presses_next        = presses_reg;
        time_pulses_next    = 4'd0;

        bl_state_t0 = backlight_reg;
        bl_secs_t0  = backlight_secs_reg;
        fifth_inc   = fifth_count_reg + 3'd1;
        sec_tick    = (fifth_inc >= FIFTHS_PER_SECOND);
        sec_t1      = seconds_reg;
        min_t1      = minutes_reg;
        hour_t1     = hours_reg;
        phase_now   = {phase_a, phase_a ^ phase_b};
        phase_diff  = last_phase_reg - phase_now;
        qs_t1       = quarter_steps_reg;
        wake        = 1'b0;
        deb_inc     = debounce_reg + 3'd1;

        case (op)
            OP_PULSE:
            begin
                pulse_counter_next = pulse_counter_reg + 32'd1;
                if (minute_pulses_reg < MINUTE_PULSES_MAX)
                begin
                    minute_pulses_next = minute_pulses_reg + 16'd1;
                end
                beeper_next = beeper_reg | sound_enable_reg;
                led_next    = led_reg | led_enable_reg;
            end
            OP_BEEP_DONE:
            begin
                beeper_next = 1'b0;
                led_next    = 1'b0;
            end
            OP_TICK:
            begin
                // auto-off is checked before this tick's second is counted
                if (battery_mode_reg && backlight_reg &&
                    (backlight_secs_reg >= backlight_timeout_reg))
                begin
                    bl_state_t0 = 1'b0;
                    bl_secs_t0  = 8'd0;
                end
                backlight_next      = bl_state_t0;
                backlight_secs_next = bl_secs_t0;
                fifth_count_next    = fifth_inc;
                if (sec_tick)
                begin
                    fifth_count_next    = 3'd0;
                    sec_t1              = seconds_reg + 6'd1;
                    seconds_total_next  = seconds_total_reg + 32'd1;
                    time_pulses_next[0] = 1'b1;
                    if (bl_state_t0)
                    begin
                        backlight_secs_next = bl_secs_t0 + 8'd1;
                    end
                end
                seconds_next = sec_t1;
                if (sec_t1 >= SECONDS_PER_MINUTE)
                begin
                    seconds_next        = 6'd0;
                    min_t1              = minutes_reg + 6'd1;
                    time_pulses_next[1] = 1'b1;
                    if (minute_pulses_reg <= BG_LIMIT)
                    begin
                        last_bg_next      = minute_pulses_reg[4:0];
                        bg_total_next     = bg_total_reg + {16'd0, minute_pulses_reg};
                        good_minutes_next = good_minutes_reg + 32'd1;
                    end
                    else
                    begin
                        last_bg_next = 5'd0;
                    end
                    minute_pulses_next = 16'd0;
                end
                minutes_next = min_t1;
                if (min_t1 >= MINUTES_PER_HOUR)
                begin
                    minutes_next        = 6'd0;
                    hour_t1             = hours_reg + 5'd1;
                    time_pulses_next[2] = 1'b1;
                end
                hours_next = hour_t1;
                if (hour_t1 >= HOURS_PER_DAY)
                begin
                    hours_next          = 5'd0;
                    days_next           = days_reg + 16'd1;
                    time_pulses_next[3] = 1'b1;
                end
            end
            OP_ENCODER:
            begin
                // odd diff is one gray step; even diff (no move or a jump) is ignored
                if (phase_diff[0])
                begin
                    last_phase_next = phase_now;
                    qs_t1 = phase_diff[1] ? quarter_steps_reg + 2'd1
                                          : quarter_steps_reg - 2'd1;
                    quarter_steps_next = qs_t1;
                    if (qs_t1 == 2'd0)
                    begin
                        wake = 1'b1;
                        if (phase_diff[1])
                        begin
                            if (knob_single_reg < KNOB_MAX)
                            begin
                                knob_single_next = knob_single_reg + 7'd1;
                            end
                            if (knob_double_reg < KNOB_MAX)
                            begin
                                knob_double_next = knob_double_reg + 7'd2;
                            end
                        end
                        else
                        begin
                            if (knob_single_reg != 7'd0)
                            begin
                                knob_single_next = knob_single_reg - 7'd1;
                            end
                            knob_double_next = (knob_double_reg >= 7'd2) ?
                                               knob_double_reg - 7'd2 : 7'd0;
                        end
                    end
                end

                if (!button && !button_held_reg)
                begin
                    debounce_next = 3'd0;
                end
                else if (button && button_held_reg)
                begin
                    debounce_next = DEBOUNCE_SAMPLES;
                end
                else if (!button && button_held_reg)
                begin
                    if (debounce_reg <= 3'd1)
                    begin
                        debounce_next    = 3'd0;
                        button_held_next = 1'b0;
                    end
                    else
                    begin
                        debounce_next = debounce_reg - 3'd1;
                    end
                end
                else
                begin
                    debounce_next = deb_inc;
                    if (deb_inc >= DEBOUNCE_SAMPLES)
                    begin
                        wake             = 1'b1;
                        presses_next     = presses_reg + 16'd1;
                        button_held_next = 1'b1;
                    end
                end

                if (wake && battery_mode_reg)
                begin
                    backlight_next      = 1'b1;
                    backlight_secs_next = 8'd0;
                end
            end
            default:
            begin
            end
        endcase

        result_next.indicators             = {backlight_next, led_next, beeper_next};
        result_next.time_pulses            = time_pulses_next;
        result_next.pulse_total            = pulse_counter_next;
        result_next.background_last_minute = last_bg_next;
        result_next.background_sum         = bg_total_next;
        result_next.valid_minutes          = good_minutes_next;
        result_next.elapsed_seconds        = seconds_total_next;
        result_next.day_count              = days_next;
        result_next.knob_position          = knob_single_next;
        result_next.knob_position_double   = knob_double_next;
        result_next.press_count            = presses_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg      <= 1'b0;
            led_enable_reg        <= 1'b0;
            battery_mode_reg      <= 1'b0;
            backlight_timeout_reg <= BACKLIGHT_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SOUND_ENABLE:      sound_enable_reg      <= cfg_data[0];
                CFG_LED_ENABLE:        led_enable_reg        <= cfg_data[0];
                CFG_BATTERY_MODE:      battery_mode_reg      <= cfg_data[0];
                CFG_BACKLIGHT_TIMEOUT: backlight_timeout_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_counter_reg  <= '0;
            minute_pulses_reg  <= '0;
            last_bg_reg        <= '0;
            bg_total_reg       <= '0;
            good_minutes_reg   <= '0;
            fifth_count_reg    <= '0;
            seconds_reg        <= '0;
            minutes_reg        <= '0;
            hours_reg          <= '0;
            days_reg           <= '0;
            seconds_total_reg  <= '0;
            backlight_reg      <= 1'b1;
            backlight_secs_reg <= '0;
            beeper_reg         <= 1'b0;
            led_reg            <= 1'b0;
            last_phase_reg     <= '0;
            quarter_steps_reg  <= '0;
            knob_single_reg    <= '0;
            knob_double_reg    <= '0;
            button_held_reg    <= 1'b0;
            debounce_reg       <= '0;
            presses_reg        <= '0;
        end
        else if (push)
        begin
            pulse_counter_reg  <= pulse_counter_next;
            minute_pulses_reg  <= minute_pulses_next;
            last_bg_reg        <= last_bg_next;
            bg_total_reg       <= bg_total_next;
            good_minutes_reg   <= good_minutes_next;
            fifth_count_reg    <= fifth_count_next;
            seconds_reg        <= seconds_next;
            minutes_reg        <= minutes_next;
            hours_reg          <= hours_next;
            days_reg           <= days_next;
            seconds_total_reg  <= seconds_total_next;
            backlight_reg      <= backlight_next;
            backlight_secs_reg <= backlight_secs_next;
            beeper_reg         <= beeper_next;
            led_reg            <= led_next;
            last_phase_reg     <= last_phase_next;
            quarter_steps_reg  <= quarter_steps_next;
            knob_single_reg    <= knob_single_next;
            knob_double_reg    <= knob_double_next;
            button_held_reg    <= button_held_next;
            debounce_reg       <= debounce_next;
            presses_reg        <= presses_next;
        end
    end

    // output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_valid_reg)
            begin
                head_valid_reg <= pop ? (skid_valid_reg || push) : 1'b1;
            end
            else
            begin
                head_valid_reg <= push;
            end

            if (pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (push && head_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output queue payload
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            head_reg <= skid_reg;
        end
        else if (push && (!head_valid_reg || pop))
        begin
            head_reg <= result_next;
        end

        if (push && head_valid_reg && !pop)
        begin
            skid_reg <= result_next;
        end
    end

    assign result_valid           = head_valid_reg;
    assign indicators             = head_reg.indicators;
    assign time_pulses            = head_reg.time_pulses;
    assign pulse_total            = head_reg.pulse_total;
    assign background_last_minute = head_reg.background_last_minute;
    assign background_sum         = head_reg.background_sum;
    assign valid_minutes          = head_reg.valid_minutes;
    assign elapsed_seconds        = head_reg.elapsed_seconds;
    assign day_count              = head_reg.day_count;
    assign knob_position          = head_reg.knob_position;
    assign knob_position_double   = head_reg.knob_position_double;
    assign press_count            = head_reg.press_count;

endmodule

// ----- sim/panel_checker.sv -----
// Checker for the pulse counter / clock / encoder panel: predicts every result and compares it.
module panel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_ready,
    input  logic [1:0]                      operation,
    input  logic                            phase_a,
    input  logic                            phase_b,
    input  logic                            button,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  logic [2:0]                      indicators,
    input  logic [3:0]                      time_pulses,
    input  logic [31:0]                     pulse_total,
    input  logic [4:0]                      background_last_minute,
    input  logic [31:0]                     background_sum,
    input  logic [31:0]                     valid_minutes,
    input  logic [31:0]                     elapsed_seconds,
    input  logic [15:0]                     day_count,
    input  logic [6:0]                      knob_position,
    input  logic [6:0]                      knob_position_double,
    input  logic [15:0]                     press_count,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [pcce_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pcce_pkg::*;

    // register copy
    logic        sound_on_pulse;
    logic        led_on_pulse;
    logic        on_battery;
    logic [7:0]  light_timeout;

    // panel state
    logic [31:0] pulses_seen;
    logic [15:0] minute_pulses;
    logic [4:0]  last_bg;
    logic [31:0] bg_total;
    logic [31:0] good_mins;
    logic [2:0]  fifths;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    logic [15:0] days;
    logic [31:0] secs_total;
    logic        light_on;
    logic [7:0]  light_secs;
    logic        beep_on;
    logic        led_on;
    logic [1:0]  prev_phase;
    logic [1:0]  quarters;
    logic [6:0]  knob_fine;
    logic [6:0]  knob_coarse;
    logic        held;
    logic [2:0]  bounce;
    logic [15:0] presses_seen;

    result_t     readings_due[$];
    result_t     want;
    result_t     got;

    task automatic clear_panel();
        sound_on_pulse = 1'b0;
        led_on_pulse   = 1'b0;
        on_battery     = 1'b0;
        light_timeout  = BACKLIGHT_TIMEOUT_RST;
        pulses_seen    = '0;
        minute_pulses  = '0;
        last_bg        = '0;
        bg_total       = '0;
        good_mins      = '0;
        fifths         = '0;
        secs           = '0;
        mins           = '0;
        hrs            = '0;
        days           = '0;
        secs_total     = '0;
        light_on       = 1'b1;
        light_secs     = '0;
        beep_on        = 1'b0;
        led_on         = 1'b0;
        prev_phase     = '0;
        quarters       = '0;
        knob_fine      = '0;
        knob_coarse    = '0;
        held           = 1'b0;
        bounce         = '0;
        presses_seen   = '0;
    endtask

    task automatic load_register(input cfg_index_t idx, input logic [7:0] data);
        case (idx)
            CFG_SOUND_ENABLE:      sound_on_pulse = data[0];
            CFG_LED_ENABLE:        led_on_pulse   = data[0];
            CFG_BATTERY_MODE:      on_battery     = data[0];
            CFG_BACKLIGHT_TIMEOUT: light_timeout  = data;
            default: ;
        endcase
    endtask

    task automatic wake_light();
        if (on_battery)
        begin
            light_on   = 1'b1;
            light_secs = 8'd0;
        end
    endtask

    task automatic run_tick(output logic [3:0] marks);
        marks = 4'd0;
        // auto-off is judged before this tick's second is counted
        if (on_battery && light_on && light_secs >= light_timeout)
        begin
            light_on   = 1'b0;
            light_secs = 8'd0;
        end
        fifths = fifths + 3'd1;
        if (fifths >= FIFTHS_PER_SECOND)
        begin
            fifths     = 3'd0;
            secs       = secs + 6'd1;
            secs_total = secs_total + 32'd1;
            if (light_on)
                light_secs = light_secs + 8'd1;
            marks[0] = 1'b1;
        end
        if (secs >= SECONDS_PER_MINUTE)
        begin
            secs     = 6'd0;
            mins     = mins + 6'd1;
            marks[1] = 1'b1;
            if (minute_pulses <= BG_LIMIT)
            begin
                last_bg   = minute_pulses[4:0];
                bg_total  = bg_total + {16'd0, minute_pulses};
                good_mins = good_mins + 32'd1;
            end
            else
            begin
                last_bg = 5'd0;
            end
            minute_pulses = 16'd0;
        end
        if (mins >= MINUTES_PER_HOUR)
        begin
            mins     = 6'd0;
            hrs      = hrs + 5'd1;
            marks[2] = 1'b1;
        end
        if (hrs >= HOURS_PER_DAY)
        begin
            hrs      = 5'd0;
            days     = days + 16'd1;
            marks[3] = 1'b1;
        end
    endtask

    task automatic sample_knob(input logic a, input logic b, input logic btn);
        logic [1:0] now;
        logic [1:0] diff;
        now  = {a, a ^ b};
        diff = prev_phase - now;
        // even difference: no move or two gray states at once, ignored
        if (diff[0])
        begin
            prev_phase = now;
            quarters   = diff[1] ? quarters + 2'd1 : quarters - 2'd1;
            if (quarters == 2'd0)
            begin
                wake_light();
                if (diff[1])
                begin
                    if (knob_fine < KNOB_MAX)
                        knob_fine = knob_fine + 7'd1;
                    if (knob_coarse < KNOB_MAX)
                        knob_coarse = knob_coarse + 7'd2;
                end
                else
                begin
                    if (knob_fine > 7'd0)
                        knob_fine = knob_fine - 7'd1;
                    knob_coarse = (knob_coarse >= 7'd2) ? knob_coarse - 7'd2 : 7'd0;
                end
            end
        end

        if (!btn && !held)
        begin
            bounce = 3'd0;
        end
        else if (btn && held)
        begin
            bounce = DEBOUNCE_SAMPLES;
        end
        else if (!btn && held)
        begin
            if (bounce <= 3'd1)
            begin
                bounce = 3'd0;
                held   = 1'b0;
            end
            else
            begin
                bounce = bounce - 3'd1;
            end
        end
        else
        begin
            bounce = bounce + 3'd1;
            if (bounce >= DEBOUNCE_SAMPLES)
            begin
                wake_light();
                presses_seen = presses_seen + 16'd1;
                held         = 1'b1;
            end
        end
    endtask

    task automatic step_panel(input op_t op, input logic a, input logic b, input logic btn,
                              output result_t r);
        logic [3:0] marks;
        marks = 4'd0;
        case (op)
            OP_PULSE:
            begin
                pulses_seen = pulses_seen + 32'd1;
                if (minute_pulses != MINUTE_PULSES_MAX)
                    minute_pulses = minute_pulses + 16'd1;
                if (sound_on_pulse)
                    beep_on = 1'b1;
                if (led_on_pulse)
                    led_on = 1'b1;
            end
            OP_BEEP_DONE:
            begin
                beep_on = 1'b0;
                led_on  = 1'b0;
            end
            OP_TICK: run_tick(marks);
            default: sample_knob(a, b, btn);
        endcase
        r.indicators             = {light_on, led_on, beep_on};
        r.time_pulses            = marks;
        r.pulse_total            = pulses_seen;
        r.background_last_minute = last_bg;
        r.background_sum         = bg_total;
        r.valid_minutes          = good_mins;
        r.elapsed_seconds        = secs_total;
        r.day_count              = days;
        r.knob_position          = knob_fine;
        r.knob_position_double   = knob_coarse;
        r.press_count            = presses_seen;
    endtask

    task automatic check_field(input string label, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            if (mismatches < 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d", $time, label, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_panel();
            readings_due.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
                load_register(cfg_index_t'(cfg_index), cfg_data);

            if (result_valid && result_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result transaction with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    got.indicators             = indicators;
                    got.time_pulses            = time_pulses;
                    got.pulse_total            = pulse_total;
                    got.background_last_minute = background_last_minute;
                    got.background_sum         = background_sum;
                    got.valid_minutes          = valid_minutes;
                    got.elapsed_seconds        = elapsed_seconds;
                    got.day_count              = day_count;
                    got.knob_position          = knob_position;
                    got.knob_position_double   = knob_position_double;
                    got.press_count            = press_count;
                    check_field("indicators", 32'(want.indicators), 32'(got.indicators));
                    check_field("time_pulses", 32'(want.time_pulses), 32'(got.time_pulses));
                    check_field("pulse_total", want.pulse_total, got.pulse_total);
                    check_field("background_last_minute", 32'(want.background_last_minute),
                                32'(got.background_last_minute));
                    check_field("background_sum", want.background_sum, got.background_sum);
                    check_field("valid_minutes", want.valid_minutes, got.valid_minutes);
                    check_field("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
                    check_field("day_count", 32'(want.day_count), 32'(got.day_count));
                    check_field("knob_position", 32'(want.knob_position),
                                32'(got.knob_position));
                    check_field("knob_position_double", 32'(want.knob_position_double),
                                32'(got.knob_position_double));
                    check_field("press_count", 32'(want.press_count), 32'(got.press_count));
                end
            end

            if (item_valid && item_ready)
            begin
                step_panel(op_t'(operation), phase_a, phase_b, button, want);
                readings_due.push_back(want);
            end

            outstanding <= readings_due.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives events and register writes into the panel and reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcce_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 250000;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  operation  = 2'd0;
    logic        phase_a    = 1'b0;
    logic        phase_b    = 1'b0;
    logic        button     = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  indicators;
    logic [3:0]  time_pulses;
    logic [31:0] pulse_total;
    logic [4:0]  background_last_minute;
    logic [31:0] background_sum;
    logic [31:0] valid_minutes;
    logic [31:0] elapsed_seconds;
    logic [15:0] day_count;
    logic [6:0]  knob_position;
    logic [6:0]  knob_position_double;
    logic [15:0] press_count;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;

    bit          pace      = 1'b1;   // random gaps and stalls on both channels
    bit          hold_req  = 1'b0;   // asks the result side for one long stall
    bit          hold_done = 1'b0;   // result side has served the long stall
    logic [1:0]  knob_pos  = 2'd0;   // gray position driven on the encoder pins
    bit          btn_level = 1'b0;
    int          btn_run   = 0;

    pulse_counter_clock_encoder_panel uut (.*);

    panel_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit coin();
        return bit'($urandom_range(0, 1));
    endfunction

    task automatic offer_event(input op_t op, input bit a, input bit b, input bit btn);
        int gap;
        gap = pace ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        phase_a    <= a;
        phase_b    <= b;
        button     <= btn;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic offer_encoder(input bit btn);
        offer_event(OP_ENCODER, knob_pos[1], knob_pos[1] ^ knob_pos[0], btn);
    endtask

    task automatic turn_knob(input int count, input bit cw);
        repeat (count)
        begin
            knob_pos = knob_pos + (cw ? 2'd1 : 2'd3);
            offer_encoder(1'b0);
        end
    endtask

    // block is idle once every transaction has come back
    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_panel(input bit snd, input bit led, input bit batt,
                                 input logic [7:0] tmo);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SOUND_ENABLE;
        cfg_data  <= {7'd0, snd};
        @(posedge clk);
        cfg_index <= CFG_LED_ENABLE;
        cfg_data  <= {7'd0, led};
        @(posedge clk);
        cfg_index <= CFG_BATTERY_MODE;
        cfg_data  <= {7'd0, batt};
        @(posedge clk);
        cfg_index <= CFG_BACKLIGHT_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // mostly ticks; the pulse rate changes every clock minute so some minutes
    // stay under the background limit and some go over
    task automatic soak_clock(input int n_ticks, input int knob_permille);
        int ticks;
        int rate;
        int r;
        ticks = 0;
        rate  = $urandom_range(0, 120);
        while (ticks < n_ticks)
        begin
            r = $urandom_range(0, 999);
            if (r < rate)
            begin
                offer_event(OP_PULSE, coin(), coin(), coin());
            end
            else if (r < rate + knob_permille)
            begin
                turn_knob(1, coin());
            end
            else if (r == 999)
            begin
                offer_event(OP_BEEP_DONE, coin(), coin(), coin());
            end
            else
            begin
                offer_event(OP_TICK, coin(), coin(), coin());
                ticks++;
                if (ticks % 300 == 0)
                    rate = $urandom_range(0, 120);
            end
        end
    endtask

    task automatic random_phase(input int n_items, input int pulse_pct, input int cw_pct,
                                input int hold_at);
        int i;
        int r;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
                pace = ($urandom_range(0, 3) != 0);
            if (i == hold_at)
                hold_req = 1'b1;
            if (btn_run == 0)
            begin
                btn_level = ~btn_level;
                btn_run   = $urandom_range(1, 9);
            end
            btn_run--;
            r = $urandom_range(0, 99);
            if (r < pulse_pct)
            begin
                offer_event(OP_PULSE, coin(), coin(), coin());
            end
            else if (r < pulse_pct + 8)
            begin
                offer_event(OP_BEEP_DONE, coin(), coin(), coin());
            end
            else if (r < 55)
            begin
                offer_event(OP_TICK, coin(), coin(), coin());
            end
            else
            begin
                // mostly clean quadrature steps, some jumps and repeats
                r = $urandom_range(0, 99);
                if (r < 6)
                    knob_pos = knob_pos + 2'd2;
                else if (r >= 12)
                    knob_pos = knob_pos + (($urandom_range(0, 99) < cw_pct) ? 2'd1 : 2'd3);
                offer_encoder(btn_level);
            end
        end
    endtask

    // result side
    initial
    begin
        int stall;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
            begin
                stall = pace ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // indicators disabled at reset
        offer_event(OP_PULSE, 1'b1, 1'b1, 1'b1);
        offer_event(OP_BEEP_DONE, 1'b0, 1'b0, 1'b0);
        settle();
        // zero timeout drops the backlight on the first tick
        program_panel(1'b1, 1'b1, 1'b1, 8'd0);
        offer_event(OP_PULSE, 1'b0, 1'b0, 1'b0);
        offer_event(OP_BEEP_DONE, 1'b1, 1'b1, 1'b1);
        offer_event(OP_TICK, 1'b1, 1'b0, 1'b1);
        turn_knob(4, 1'b0);         // decrement at zero, wakes backlight
        turn_knob(4, 1'b1);
        knob_pos = knob_pos + 2'd2; // jumps are ignored
        offer_encoder(1'b0);
        knob_pos = knob_pos + 2'd2;
        offer_encoder(1'b0);
        repeat (5) offer_encoder(1'b1);
        repeat (5) offer_encoder(1'b0);
        settle();

        // back-to-back stretch across a full clock minute
        pace = 1'b0;
        program_panel(1'b1, 1'b1, 1'b0, 8'd255);
        soak_clock(310, 2);
        settle();
        pace = 1'b1;

        program_panel(1'b1, 1'b1, 1'b1, 8'd1);
        random_phase(200, 5, 20, 100);
        settle();
        program_panel(1'b0, 1'b0, 1'b1, 8'd255);
        random_phase(200, 2, 50, -1);
        settle();
        program_panel(1'b1, 1'b0, 1'b1, 8'd0);
        random_phase(200, 12, 80, -1);
        settle();
        program_panel(1'b0, 1'b1, 1'b0, 8'd7);
        random_phase(200, 3, 30, -1);
        settle();
        program_panel(coin(), coin(), 1'b1, 8'($urandom_range(1, 15)));
        random_phase(200, 8, 60, -1);
        settle();
        program_panel(1'b1, 1'b1, 1'b1, 8'($urandom_range(2, 6)));
        random_phase(100, 1, 10, -1);
        settle();

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pcce_pkg.sv
rtl/core/pulse_counter_clock_encoder_panel.sv
sim/panel_checker.sv
sim/tb.sv
